FILE: rtl/entity_slot_allocator_unit_assert.svh
// Assertion macros used by the checker file esa_checker.sv.
`ifndef ENTITY_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define ENTITY_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ESA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

// Consequent checked in the cycle after the antecedent.
`define ESA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot allocator check failed");

`endif

FILE: rtl/esa_pkg.sv
package esa_pkg;

  localparam int SLOT_W   = 10;
  localparam int TAG_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int LIVE_W   = 11;
  localparam int STATUS_W = 2;

  localparam int S_TAG_LSB   = 0;
  localparam int S_COUNT_LSB = S_TAG_LSB + TAG_W;
  localparam int S_IDX_LSB   = S_COUNT_LSB + COUNT_W;
  localparam int S_USED_W    = S_IDX_LSB + SLOT_W;
  localparam int S_DATA_W    = ((S_USED_W + 7) / 8) * 8;

  localparam int M_SLOT_LSB   = 0;
  localparam int M_STATUS_LSB = M_SLOT_LSB + SLOT_W;
  localparam int M_TAG_LSB    = M_STATUS_LSB + STATUS_W;
  localparam int M_LIVE_LSB   = M_TAG_LSB + TAG_W;
  localparam int M_USED_W     = M_LIVE_LSB + LIVE_W;
  localparam int M_DATA_W     = ((M_USED_W + 7) / 8) * 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_e;

endpackage

FILE: rtl/entity_slot_allocator_unit.sv
// Lowest-free-slot allocator over a table of type tags.
// Input channel s_axis: tuser is the opcode (0 allocate, 1 free), tdata carries
// type_tag, alloc_count and slot_index. Output channel m_axis: one transfer per
// slot granted or freed, tlast on the final one of a request; a refused request
// gives a single transfer with tlast set.
// One request is taken at a time: tready is high only while the sequencer idles.
// A free issues the tag read in the accept cycle; the free check then tests the
// tag and loads the result. A free at or above the high-water end is refused
// without a tag read.
// An allocate passes the request check, then fills the gaps below the high-water
// end, lowest first, each fill followed by a scan up to the next gap, and then
// appends slots at the high-water end; a refused allocate goes from the request
// check straight to the reply. The tag memory has one write port and one read
// port; the gap scan reads it once a cycle.
// The output register holds a result until the receiver takes it; a stalled
// receiver stalls the sequencer at its next result, never drops one.
// Reset clears the counters and marks every slot free at once: tags are only
// read below the high-water end, which reset sets to zero, so the tag memory
// needs no clearing pass and the block is ready as soon as reset is released.
module entity_slot_allocator_unit #(
  parameter int SLOTS     = 1024,
  parameter int TAG_BITS  = 16,
  parameter int MAX_BATCH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // type_tag[15:0], alloc_count[20:16], slot_index[30:21], zero pad
  input  logic [esa_pkg::S_DATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // result_slot[9:0], status[11:10], freed_tag[27:12], live_slots[38:28], zero pad
  output logic [esa_pkg::M_DATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import esa_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int BAT_W = $clog2(MAX_BATCH + 1);
  localparam logic [CNT_W-1:0] NO_GAP = CNT_W'(SLOTS);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ALLOC_CHK = 3'd1;
  localparam logic [2:0] S_FILL      = 3'd2;
  localparam logic [2:0] S_SCAN      = 3'd3;
  localparam logic [2:0] S_APPEND    = 3'd4;
  localparam logic [2:0] S_FREE_CHK  = 3'd5;
  localparam logic [2:0] S_REPLY     = 3'd6;

  logic [2:0]          state_q, state_d;
  logic                op_q, op_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [SLOT_W-1:0]   idx_q, idx_d;
  status_e             rep_status_q, rep_status_d;
  logic [BAT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    end_q, end_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [CNT_W-1:0]    gapc_q, gapc_d;
  logic [CNT_W-1:0]    lgap_q, lgap_d;
  logic [CNT_W-1:0]    scan_q, scan_d;
  logic                chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]    chk_addr_q, chk_addr_d;

  logic [TAG_BITS-1:0] mem [SLOTS];
  logic [TAG_BITS-1:0] rd_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [TAG_BITS-1:0] mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;

  logic                m_vld_q;
  logic [M_DATA_W-1:0] m_data_q;
  logic                m_last_q;

  logic                out_free;
  logic                emit;
  logic [SLOT_W-1:0]   emit_slot;
  status_e             emit_status;
  logic [TAG_W-1:0]    emit_tag;
  logic [CNT_W-1:0]    emit_live;
  logic                emit_last;
  logic [IDX_W-1:0]    idx_addr;
  logic [IDX_W-1:0]    gap_addr;
  logic [IDX_W-1:0]    end_addr;
  logic [M_DATA_W-1:0] emit_data;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !m_vld_q || m_axis_tready;
  assign idx_addr      = IDX_W'(idx_q);
  assign gap_addr      = lgap_q[IDX_W-1:0];
  assign end_addr      = end_q[IDX_W-1:0];

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    tag_d        = tag_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    rep_status_d = rep_status_q;
    rem_d        = rem_q;
    end_d        = end_q;
    used_d       = used_q;
    gapc_d       = gapc_q;
    lgap_d       = lgap_q;
    scan_d       = scan_q;
    chk_vld_d    = chk_vld_q;
    chk_addr_d   = chk_addr_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    emit         = 1'b0;
    emit_slot    = '0;
    emit_status  = STATUS_OK;
    emit_tag     = '0;
    emit_live    = used_q;
    emit_last    = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = s_axis_tuser;
          tag_d = TAG_BITS'(s_axis_tdata[S_TAG_LSB +: TAG_W]);
          cnt_d = s_axis_tdata[S_COUNT_LSB +: COUNT_W];
          idx_d = s_axis_tdata[S_IDX_LSB +: SLOT_W];
          if (s_axis_tuser == OP_ALLOC) begin
            state_d = S_ALLOC_CHK;
          end else if (32'(idx_d) >= 32'(SLOTS) || 32'(idx_d) >= 32'(end_q)) begin
            rep_status_d = STATUS_BAD;
            state_d      = S_REPLY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(idx_d);
            state_d   = S_FREE_CHK;
          end
        end
      end
      S_ALLOC_CHK: begin
        if (tag_q == '0 || cnt_q == '0 || 32'(cnt_q) > 32'(MAX_BATCH)) begin
          rep_status_d = STATUS_BAD;
          state_d      = S_REPLY;
        end else if (32'(used_q) >= 32'(SLOTS) ||
                     32'(cnt_q) > 32'(SLOTS) - 32'(used_q)) begin
          rep_status_d = STATUS_FULL;
          state_d      = S_REPLY;
        end else begin
          rem_d   = BAT_W'(cnt_q);
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (gapc_q != '0 && rem_q != '0 && lgap_q < NO_GAP) begin
          if (out_free) begin
            mem_we      = 1'b1;
            mem_waddr   = gap_addr;
            mem_wdata   = tag_q;
            used_d      = used_q + CNT_W'(1);
            gapc_d      = gapc_q - CNT_W'(1);
            rem_d       = rem_q - BAT_W'(1);
            emit        = 1'b1;
            emit_slot   = SLOT_W'(lgap_q);
            emit_live   = used_d;
            emit_last   = (rem_d == '0);
            scan_d      = lgap_q + CNT_W'(1);
            chk_vld_d   = 1'b0;
            state_d     = S_SCAN;
          end
        end else begin
          state_d = S_APPEND;
        end
      end
      S_SCAN: begin
        if (chk_vld_q && rd_q == '0) begin
          lgap_d    = CNT_W'(chk_addr_q);
          chk_vld_d = 1'b0;
          state_d   = S_FILL;
        end else if (scan_q < end_q) begin
          mem_re     = 1'b1;
          mem_raddr  = scan_q[IDX_W-1:0];
          chk_vld_d  = 1'b1;
          chk_addr_d = scan_q[IDX_W-1:0];
          scan_d     = scan_q + CNT_W'(1);
        end else begin
          lgap_d    = NO_GAP;
          chk_vld_d = 1'b0;
          state_d   = S_FILL;
        end
      end
      S_APPEND: begin
        if (rem_q != '0 && end_q < NO_GAP) begin
          if (out_free) begin
            mem_we    = 1'b1;
            mem_waddr = end_addr;
            mem_wdata = tag_q;
            used_d    = used_q + CNT_W'(1);
            rem_d     = rem_q - BAT_W'(1);
            end_d     = end_q + CNT_W'(1);
            emit      = 1'b1;
            emit_slot = SLOT_W'(end_q);
            emit_live = used_d;
            emit_last = (rem_d == '0);
          end
        end else begin
          if (used_q > end_q) begin
            end_d = used_q;
          end
          state_d = S_IDLE;
        end
      end
      S_FREE_CHK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_slot = idx_q;
          if (rd_q == '0) begin
            emit_status = STATUS_BAD;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = idx_addr;
            mem_wdata = '0;
            if (used_q != '0) begin
              used_d = used_q - CNT_W'(1);
            end
            if (end_q != '0 && CNT_W'(idx_addr) == end_q - CNT_W'(1)) begin
              end_d = end_q - CNT_W'(1);
            end else begin
              gapc_d = gapc_q + CNT_W'(1);
              if (CNT_W'(idx_addr) < lgap_q) begin
                lgap_d = CNT_W'(idx_addr);
              end
            end
            emit_tag  = TAG_W'(rd_q);
            emit_live = used_d;
          end
          state_d = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = rep_status_q;
          emit_slot   = (op_q == OP_FREE) ? idx_q : '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    emit_data = '0;
    emit_data[M_SLOT_LSB +: SLOT_W]     = emit_slot;
    emit_data[M_STATUS_LSB +: STATUS_W] = emit_status;
    emit_data[M_TAG_LSB +: TAG_W]       = emit_tag;
    emit_data[M_LIVE_LSB +: LIVE_W]     = LIVE_W'(emit_live);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      end_q     <= '0;
      used_q    <= '0;
      gapc_q    <= '0;
      lgap_q    <= NO_GAP;
      chk_vld_q <= 1'b0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      end_q     <= end_d;
      used_q    <= used_d;
      gapc_q    <= gapc_d;
      lgap_q    <= lgap_d;
      chk_vld_q <= chk_vld_d;
      if (emit) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tag_q        <= tag_d;
    cnt_q        <= cnt_d;
    idx_q        <= idx_d;
    rep_status_q <= rep_status_d;
    rem_q        <= rem_d;
    scan_q       <= scan_d;
    chk_addr_q   <= chk_addr_d;
    if (emit) begin
      m_data_q <= emit_data;
      m_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

FILE: rtl/esa_checker.sv
`include "entity_slot_allocator_unit_assert.svh"

module esa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [esa_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import esa_pkg::*;

  logic s_xfer;
  logic m_xfer;
  logic m_stall;
  logic m_refused;

  assign s_xfer    = s_axis_tvalid && s_axis_tready;
  assign m_xfer    = m_axis_tvalid && m_axis_tready;
  assign m_stall   = m_axis_tvalid && !m_axis_tready;
  assign m_refused = m_axis_tvalid && (m_axis_tdata[M_STATUS_LSB +: STATUS_W] != STATUS_OK);

  `ESA_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, m_stall, m_axis_tvalid)
  `ESA_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, m_stall, $stable({m_axis_tlast, m_axis_tdata}))
  `ESA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_xfer, !s_axis_tready)
  `ESA_ASSERT_NEXT(a_busy_mid_batch, clk_i, rst_ni, m_xfer && !m_axis_tlast, !s_axis_tready)
  `ESA_ASSERT_SAME(a_refusal_is_last, clk_i, rst_ni, m_refused, m_axis_tlast)

endmodule

bind entity_slot_allocator_unit esa_checker u_esa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
